// ----- src/hermite_key_interpolator_assert.svh -----
// assertion macros used by the interpolator top level
`ifndef HERMITE_KEY_INTERPOLATOR_ASSERT_SVH
`define HERMITE_KEY_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define HKI_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hki check failed");
`define HKI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hki check failed");
`else
`define HKI_ASSERT_IMPLY(label, ante, cons)
`define HKI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/hki_pkg.sv -----
// shared types, constants and control structs for the hermite key interpolator
package hki_pkg;

    // tangent store
    localparam int TANGENT_SLOTS = 6;
    localparam int COUNT_W       = 3;
    localparam logic [COUNT_W-1:0] SLOTS_FULL = COUNT_W'(TANGENT_SLOTS);

    // data formats
    localparam int DATA_W   = 32;
    localparam int DELTA_W  = 17;
    localparam int FLAGS_W  = 6;
    localparam int LANES    = 3;
    localparam int SQ_W     = 2 * DELTA_W;
    localparam int CUBE_W   = 49;
    localparam int Q48_W    = 51;
    localparam int H_W      = 31;
    localparam int PROD_W   = 2 * DATA_W;

    // input word layout, lowest bit first
    localparam int TANGENT_LSB = 0;
    localparam int START_LSB   = TANGENT_LSB + DATA_W;
    localparam int END_LSB     = START_LSB + LANES * DATA_W;
    localparam int FLAGS_LSB   = END_LSB + LANES * DATA_W;
    localparam int DELTA_LSB   = FLAGS_LSB + FLAGS_W;
    localparam int IN_BITS     = DELTA_LSB + DELTA_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = LANES * DATA_W;

    localparam logic [DELTA_W-1:0] DELTA_ONE = DELTA_W'(65536);

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_ROUTE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_ACC,
        S_DONE
    } state_t;

    // which term of the blend a lane multiplies
    typedef enum logic [1:0]
    {
        TERM_START,
        TERM_END,
        TERM_IN,
        TERM_OUT
    } term_t;

    typedef logic signed [DATA_W-1:0] coef_t;
    typedef coef_t coef_set_t [4];
    typedef logic [DATA_W-1:0] tang_set_t [TANGENT_SLOTS];

    typedef struct packed
    {
        logic push;
        logic load;
        logic step_en;
        logic [COUNT_W-1:0] step;
        logic clear;
    } route_ctrl_t;

    typedef struct packed
    {
        logic ld_t;
        logic ld_sq;
        logic ld_cube;
        logic ld_h;
    } basis_ctrl_t;

    typedef struct packed
    {
        logic  load;
        logic  mul_en;
        term_t sel;
        logic  acc_clr;
        logic  acc_en;
    } lane_ctrl_t;

endpackage

// ----- src/hermite_key_interpolator.sv -----
// top level: sequencer, tangent router, basis unit, three axis lanes, result register
//
//  channel  dir  tdata fields (low bit first)                         tuser
//  s_axis   in   tangent_word, start_x/y/z, end_x/y/z, flags, delta   opcode
//  m_axis   out  out_x, out_y, out_z                                  -
//
// a tangent push returns no word
// an evaluate, once accepted, loads the result register after six
// routing steps (basis powers run alongside), four products on one
// multiplier per lane, one accumulate, one round-and-saturate step
// input is refused while an evaluate runs; a held result stalls only the last step
// rst_n clears the sequencer, the tangent count and the result valid flag

`include "hermite_key_interpolator_assert.svh"

module hermite_key_interpolator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tangent_word, start_x, start_y, start_z, end_x, end_y, end_z,
    // tangent_flags, delta, zero pad
    input  logic [hki_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_x, out_y, out_z
    output logic [hki_pkg::OUT_DATA_W-1:0]    m_tdata
);

    hki_pkg::state_t       state_reg;
    hki_pkg::state_t       state_next;
    logic [hki_pkg::COUNT_W-1:0] step_reg;
    logic [hki_pkg::COUNT_W-1:0] step_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [hki_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    hki_pkg::route_ctrl_t  route_ctrl;
    hki_pkg::basis_ctrl_t  basis_ctrl;
    hki_pkg::lane_ctrl_t   lane_ctrl;
    hki_pkg::coef_set_t    coef;
    hki_pkg::tang_set_t    tang;
    logic signed [hki_pkg::DATA_W-1:0] lane_res [hki_pkg::LANES];

    logic in_fire;
    logic out_free;
    logic last_step;
    logic finish;

    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_step = step_reg == hki_pkg::COUNT_W'(hki_pkg::TANGENT_SLOTS - 1);
    assign finish    = (state_reg == hki_pkg::S_DONE) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            hki_pkg::S_IDLE:
            begin
                if (in_fire && (hki_pkg::op_t'(s_tuser) == hki_pkg::OP_EVAL))
                begin
                    state_next = hki_pkg::S_ROUTE;
                    step_next  = '0;
                end
            end
            hki_pkg::S_ROUTE:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = hki_pkg::S_MUL0;
                end
            end
            hki_pkg::S_MUL0: state_next = hki_pkg::S_MUL1;
            hki_pkg::S_MUL1: state_next = hki_pkg::S_MUL2;
            hki_pkg::S_MUL2: state_next = hki_pkg::S_MUL3;
            hki_pkg::S_MUL3: state_next = hki_pkg::S_ACC;
            hki_pkg::S_ACC:  state_next = hki_pkg::S_DONE;
            hki_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = hki_pkg::S_IDLE;
                end
            end
            default: state_next = hki_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        route_ctrl = '0;
        basis_ctrl = '0;
        lane_ctrl  = '0;
        lane_ctrl.sel = hki_pkg::TERM_START;
        route_ctrl.step = step_reg;
        unique case (state_reg)
            hki_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (hki_pkg::op_t'(s_tuser) == hki_pkg::OP_PUSH)
                    begin
                        route_ctrl.push = 1'b1;
                    end
                    else
                    begin
                        route_ctrl.load = 1'b1;
                        basis_ctrl.ld_t = 1'b1;
                        lane_ctrl.load  = 1'b1;
                    end
                end
            end
            hki_pkg::S_ROUTE:
            begin
                route_ctrl.step_en = 1'b1;
                route_ctrl.clear   = last_step;
                basis_ctrl.ld_sq   = step_reg == hki_pkg::COUNT_W'(0);
                basis_ctrl.ld_cube = step_reg == hki_pkg::COUNT_W'(1);
                basis_ctrl.ld_h    = step_reg == hki_pkg::COUNT_W'(2);
            end
            hki_pkg::S_MUL0:
            begin
                lane_ctrl.mul_en = 1'b1;
                lane_ctrl.sel    = hki_pkg::TERM_START;
            end
            hki_pkg::S_MUL1:
            begin
                lane_ctrl.mul_en  = 1'b1;
                lane_ctrl.sel     = hki_pkg::TERM_END;
                lane_ctrl.acc_clr = 1'b1;
            end
            hki_pkg::S_MUL2:
            begin
                lane_ctrl.mul_en = 1'b1;
                lane_ctrl.sel    = hki_pkg::TERM_IN;
                lane_ctrl.acc_en = 1'b1;
            end
            hki_pkg::S_MUL3:
            begin
                lane_ctrl.mul_en = 1'b1;
                lane_ctrl.sel    = hki_pkg::TERM_OUT;
                lane_ctrl.acc_en = 1'b1;
            end
            hki_pkg::S_ACC:
            begin
                lane_ctrl.acc_en = 1'b1;
            end
            hki_pkg::S_DONE:
            begin
                s_tready = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hki_pkg::S_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result word valid flag
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    hki_route u_route
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (route_ctrl),
        .tangent_word  (s_tdata[hki_pkg::TANGENT_LSB +: hki_pkg::DATA_W]),
        .tangent_flags (s_tdata[hki_pkg::FLAGS_LSB +: hki_pkg::FLAGS_W]),
        .tang          (tang)
    );

    hki_basis u_basis
    (
        .clk   (clk),
        .ctrl  (basis_ctrl),
        .delta (s_tdata[hki_pkg::DELTA_LSB +: hki_pkg::DELTA_W]),
        .coef  (coef)
    );

    // one lane per axis; in-slot is the start tangent, out-slot the end tangent
    for (genvar i = 0; i < hki_pkg::LANES; i++)
    begin : g_lane
        hki_lane u_lane
        (
            .clk      (clk),
            .ctrl     (lane_ctrl),
            .start_pt (signed'(s_tdata[hki_pkg::START_LSB + i * hki_pkg::DATA_W +:
                                       hki_pkg::DATA_W])),
            .end_pt   (signed'(s_tdata[hki_pkg::END_LSB + i * hki_pkg::DATA_W +:
                                       hki_pkg::DATA_W])),
            .in_tan   (signed'(tang[i])),
            .out_tan  (signed'(tang[hki_pkg::LANES + i])),
            .coef     (coef),
            .result   (lane_res[i])
        );
    end

    // merge lane results into the output word
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            for (int k = 0; k < hki_pkg::LANES; k++)
            begin
                m_tdata_reg[k * hki_pkg::DATA_W +: hki_pkg::DATA_W] <= lane_res[k];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `HKI_ASSERT_NEXT(a_eval_starts_route, in_fire && s_tuser, state_reg == hki_pkg::S_ROUTE && step_reg == '0)
    `HKI_ASSERT_IMPLY(a_valid_from_done, $rose(m_tvalid), $past(state_reg == hki_pkg::S_DONE))
    `HKI_ASSERT_NEXT(a_done_holds, state_reg == hki_pkg::S_DONE && m_tvalid && !m_tready, state_reg == hki_pkg::S_DONE)
    `HKI_ASSERT_IMPLY(a_route_steps_bounded, state_reg == hki_pkg::S_ROUTE, step_reg < hki_pkg::COUNT_W'(hki_pkg::TANGENT_SLOTS))

endmodule

// ----- src/hki_route.sv -----
// tangent store and hand-out of stored words to the flagged slots
module hki_route
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hki_pkg::route_ctrl_t          ctrl,
    input  logic [hki_pkg::DATA_W-1:0]    tangent_word,
    input  logic [hki_pkg::FLAGS_W-1:0]   tangent_flags,
    output hki_pkg::tang_set_t            tang
);

    logic [hki_pkg::DATA_W-1:0]  store_reg [hki_pkg::TANGENT_SLOTS];
    logic [hki_pkg::COUNT_W-1:0] count_reg;
    logic [hki_pkg::COUNT_W-1:0] count_next;
    logic [hki_pkg::COUNT_W-1:0] rd_ptr_reg;
    logic [hki_pkg::COUNT_W-1:0] rd_ptr_next;
    logic [hki_pkg::FLAGS_W-1:0] flags_reg;
    logic [hki_pkg::DATA_W-1:0]  tang_reg [hki_pkg::TANGENT_SLOTS];
    logic                        slot_used;
    logic                        word_avail;

    // current slot takes a word if flagged and a stored word remains, else zero
    assign slot_used  = flags_reg[ctrl.step];
    assign word_avail = rd_ptr_reg < count_reg;

    // fill count and read pointer
    always_comb
    begin
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        if (ctrl.push && (count_reg < hki_pkg::SLOTS_FULL))
        begin
            count_next = count_reg + 1'b1;
        end
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        if (ctrl.load)
        begin
            rd_ptr_next = '0;
        end
        else if (ctrl.step_en && slot_used)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // store write, one word per push while the store is not full
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (count_reg < hki_pkg::SLOTS_FULL))
        begin
            store_reg[count_reg] <= tangent_word;
        end
    end

    // flags latch and one slot per step
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            flags_reg <= tangent_flags;
        end
        if (ctrl.step_en)
        begin
            if (slot_used && word_avail)
            begin
                tang_reg[ctrl.step] <= store_reg[rd_ptr_reg];
            end
            else
            begin
                tang_reg[ctrl.step] <= '0;
            end
        end
    end

    assign tang = tang_reg;

endmodule

// ----- src/hki_basis.sv -----
// hermite basis h1..h4 in q2.30 from the clamped position
module hki_basis
(
    input  logic                          clk,
    input  hki_pkg::basis_ctrl_t          ctrl,
    input  logic [hki_pkg::DELTA_W-1:0]   delta,
    output hki_pkg::coef_set_t            coef
);

    localparam logic [hki_pkg::Q48_W-1:0] ONE_Q48  = hki_pkg::Q48_W'(1) << 48;
    localparam logic [hki_pkg::Q48_W-1:0] HALF_LSB = hki_pkg::Q48_W'(1) << 17;
    localparam logic [hki_pkg::H_W-1:0]   ONE_Q30  = hki_pkg::H_W'(1) << 30;

    logic [hki_pkg::DELTA_W-1:0] t_reg;
    logic [hki_pkg::SQ_W-1:0]    sq_reg;
    logic [hki_pkg::CUBE_W-1:0]  cube_reg;
    logic [hki_pkg::H_W-1:0]     h1_reg;
    logic [hki_pkg::H_W-1:0]     h3_reg;
    logic [hki_pkg::H_W-1:0]     h4_reg;
    logic [hki_pkg::DELTA_W-1:0] t_clamp;
    logic [hki_pkg::Q48_W-1:0]   cube_prod;
    logic [hki_pkg::Q48_W-1:0]   t_w;
    logic [hki_pkg::Q48_W-1:0]   sq_w;
    logic [hki_pkg::Q48_W-1:0]   cube_w;
    logic [hki_pkg::Q48_W-1:0]   h1_v;
    logic [hki_pkg::Q48_W-1:0]   h3_v;
    logic [hki_pkg::Q48_W-1:0]   h4_v;
    logic [hki_pkg::H_W-1:0]     h2_w;

    // position above one is held at one
    assign t_clamp = (delta > hki_pkg::DELTA_ONE) ? hki_pkg::DELTA_ONE : delta;

    assign cube_prod = hki_pkg::Q48_W'(sq_reg) * hki_pkg::Q48_W'(t_reg);

    // basis terms in q3.48, exact but for half an output lsb added to round
    assign t_w    = hki_pkg::Q48_W'(t_reg);
    assign sq_w   = hki_pkg::Q48_W'(sq_reg);
    assign cube_w = hki_pkg::Q48_W'(cube_reg);
    assign h1_v   = (cube_w << 1) + ONE_Q48 - ((sq_w << 16) + (sq_w << 17)) + HALF_LSB;
    assign h3_v   = (t_w << 32) + cube_w - (sq_w << 17) + HALF_LSB;
    assign h4_v   = (sq_w << 16) - cube_w + HALF_LSB;

    // power and basis registers, one step each
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_t)
        begin
            t_reg <= t_clamp;
        end
        if (ctrl.ld_sq)
        begin
            sq_reg <= hki_pkg::SQ_W'(t_reg) * hki_pkg::SQ_W'(t_reg);
        end
        if (ctrl.ld_cube)
        begin
            cube_reg <= cube_prod[hki_pkg::CUBE_W-1:0];
        end
        if (ctrl.ld_h)
        begin
            h1_reg <= h1_v[48:18];
            h3_reg <= h3_v[48:18];
            h4_reg <= h4_v[48:18];
        end
    end

    // h2 completes h1 to exactly one
    assign h2_w = ONE_Q30 - h1_reg;

    assign coef[0] = signed'({1'b0, h1_reg});
    assign coef[1] = signed'({1'b0, h2_w});
    assign coef[2] = signed'({1'b0, h3_reg});
    assign coef[3] = -signed'({1'b0, h4_reg});

endmodule

// ----- src/hki_lane.sv -----
// one axis: multiply-accumulate of the four blend terms, round and saturate
module hki_lane
(
    input  logic                               clk,
    input  hki_pkg::lane_ctrl_t                ctrl,
    input  logic signed [hki_pkg::DATA_W-1:0]  start_pt,
    input  logic signed [hki_pkg::DATA_W-1:0]  end_pt,
    input  logic signed [hki_pkg::DATA_W-1:0]  in_tan,
    input  logic signed [hki_pkg::DATA_W-1:0]  out_tan,
    input  hki_pkg::coef_set_t                 coef,
    output logic signed [hki_pkg::DATA_W-1:0]  result
);

    localparam logic signed [hki_pkg::PROD_W-1:0] ROUND_HALF =
        hki_pkg::PROD_W'(1) << 29;
    localparam int R_W = hki_pkg::PROD_W - 30;

    logic signed [hki_pkg::DATA_W-1:0] start_reg;
    logic signed [hki_pkg::DATA_W-1:0] end_reg;
    logic signed [hki_pkg::PROD_W-1:0] prod_reg;
    logic signed [hki_pkg::PROD_W-1:0] acc_reg;
    logic signed [hki_pkg::DATA_W-1:0] opnd;
    logic signed [hki_pkg::DATA_W-1:0] cf;
    logic signed [hki_pkg::PROD_W-1:0] rnd;
    logic signed [R_W-1:0]             r;

    // term select
    always_comb
    begin
        case (ctrl.sel)
            hki_pkg::TERM_START:
            begin
                opnd = start_reg;
                cf   = coef[0];
            end
            hki_pkg::TERM_END:
            begin
                opnd = end_reg;
                cf   = coef[1];
            end
            hki_pkg::TERM_IN:
            begin
                opnd = in_tan;
                cf   = coef[2];
            end
            hki_pkg::TERM_OUT:
            begin
                opnd = out_tan;
                cf   = coef[3];
            end
            default:
            begin
                opnd = start_reg;
                cf   = coef[0];
            end
        endcase
    end

    // product then accumulate, one register between
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            start_reg <= start_pt;
            end_reg   <= end_pt;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= hki_pkg::PROD_W'(opnd) * hki_pkg::PROD_W'(cf);
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= prod_reg;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // round to q16.16 (floor after half added) and clip to 32 bits
    assign rnd = acc_reg + ROUND_HALF;
    assign r   = rnd[hki_pkg::PROD_W-1:30];

    always_comb
    begin
        if (r[R_W-1:hki_pkg::DATA_W-1] == '0 || r[R_W-1:hki_pkg::DATA_W-1] == '1)
        begin
            result = r[hki_pkg::DATA_W-1:0];
        end
        else if (r[R_W-1])
        begin
            result = {1'b1, {(hki_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(hki_pkg::DATA_W-1){1'b1}}};
        end
    end

endmodule
